@@ sv/gcfs_pkg.sv @@
`timescale 1ns / 1ps

package gcfs_pkg;

    // Largest grid that the block walks; register values above these clamp.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWE_W = ROW_W + 1;
    localparam int COLE_W = COL_W + 1;
    localparam int COEF_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

    // Offsets in units of 2^-17 m and their magnitudes.
    localparam int OFF_W = COEF_W + 33;
    localparam int MAG_W = OFF_W - 1;
    localparam int SH_W  = $clog2(MAG_W);

    localparam int MANT_W = 16;
    localparam int S_W    = 34;
    localparam int R_W    = 17;
    localparam int D_W    = 51;
    localparam int P_W    = 6;
    localparam int REC_W  = 33;
    localparam int T1_W   = 49;
    localparam int K_W    = 45;
    localparam int TP_W   = 95;
    localparam int ACC_W  = 128;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [13:0] K_MICRO = 14'd9000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SPACING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SPACING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_VALUE = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic signed [31:0] query_z;
    } query_t;

    typedef struct packed {
        logic signed [63:0] field_x;
        logic signed [63:0] field_y;
        logic signed [63:0] field_z;
        logic [62:0]        field_magnitude;
        logic               singular;
    } result_t;

endpackage

@@ sv/grid_charge_field_sum.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// query     in         in_valid, in_stall   in_data  (gcfs_pkg::query_t)
// result    out        out_valid, out_stall out_data (gcfs_pkg::result_t)
// config    in         cfg_write            cfg_index, cfg_data
//
// Each charge is worked on the shared 34x33 multiplier and its sequencer,
// with the 33-step reciprocal divide and the 17-step square root. A query
// walks every charge of the rows * cols grid and then takes the field norm
// (partial squares, 64 root steps).
// Reset clears all control state and loads the register defaults.
// The block takes a new item only when idle; a finished result waits in the
// output register, and the block returns to idle once that register is free.
module grid_charge_field_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  gcfs_pkg::query_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output gcfs_pkg::result_t                   out_data,
    input  logic                                cfg_write,
    input  logic [gcfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gcfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000000000000001,
        ST_KMUL   = 16'b0000000000000010,
        ST_OFFSET = 16'b0000000000000100,
        ST_SHIFT  = 16'b0000000000001000,
        ST_SQ     = 16'b0000000000010000,
        ST_SQRT   = 16'b0000000000100000,
        ST_DMUL   = 16'b0000000001000000,
        ST_NORM   = 16'b0000000010000000,
        ST_DIV    = 16'b0000000100000000,
        ST_TERM   = 16'b0000001000000000,
        ST_TACC   = 16'b0000010000000000,
        ST_NEXT   = 16'b0000100000000000,
        ST_SAT    = 16'b0001000000000000,
        ST_MSQ    = 16'b0010000000000000,
        ST_MSQRT  = 16'b0100000000000000,
        ST_FIN    = 16'b1000000000000000
    } state_t;

    // Configuration registers.
    logic [6:0]         grid_rows_reg;
    logic [6:0]         grid_cols_reg;
    logic [30:0]        x_spacing_reg;
    logic [30:0]        y_spacing_reg;
    logic signed [31:0] charge_reg;

    state_t state_reg, state_next;
    logic   phase_reg;
    logic [6:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [gcfs_pkg::ROW_W-1:0] i_reg;
    logic [gcfs_pkg::COL_W-1:0] j_reg;
    logic sing_reg;

    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic [gcfs_pkg::K_W-1:0]     k_reg;
    logic [gcfs_pkg::MAG_W-1:0]   a_reg, b_reg, c_reg;
    logic                         sx_reg, sy_reg, sz_reg;
    logic [gcfs_pkg::MANT_W-1:0]  u_reg, v_reg, w_reg;
    logic [gcfs_pkg::SH_W-1:0]    s_reg;
    logic [gcfs_pkg::S_W-1:0]     sum_reg;
    logic [gcfs_pkg::R_W-1:0]     r_reg;
    logic [gcfs_pkg::D_W-1:0]     d_reg;
    logic [gcfs_pkg::P_W-1:0]     p_reg;
    logic [31:0]                  dn_reg;
    logic [63:0]                  rem_reg;
    logic [gcfs_pkg::REC_W-1:0]   rec_reg;
    logic [gcfs_pkg::T1_W-1:0]    t1_reg;
    logic [gcfs_pkg::TP_W-1:0]    tp_reg;
    logic signed [gcfs_pkg::ACC_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [63:0]           fx_reg, fy_reg, fz_reg;
    logic [127:0]                 sq_reg;
    logic [65:0]                  mrem_reg;
    logic [63:0]                  root_reg;
    logic [gcfs_pkg::MUL_P_W-1:0] prod_reg;

    logic               out_valid_reg;
    gcfs_pkg::result_t  out_reg;

    // Clamped grid size.
    logic [gcfs_pkg::ROWE_W-1:0] rows_eff;
    logic [gcfs_pkg::COLE_W-1:0] cols_eff;

    always_comb
    begin
        int rows_i;
        int cols_i;
        rows_i = (grid_rows_reg == 7'd0) ? 1 :
                 ((int'(grid_rows_reg) > gcfs_pkg::MAX_ROWS) ? gcfs_pkg::MAX_ROWS
                                                             : int'(grid_rows_reg));
        cols_i = (grid_cols_reg == 7'd0) ? 1 :
                 ((int'(grid_cols_reg) > gcfs_pkg::MAX_COLS) ? gcfs_pkg::MAX_COLS
                                                             : int'(grid_cols_reg));
        rows_eff = gcfs_pkg::ROWE_W'(rows_i);
        cols_eff = gcfs_pkg::COLE_W'(cols_i);
    end

    // Offsets of the query from charge (i, j), doubled so that the
    // half-spacing grid positions stay integral.
    logic signed [gcfs_pkg::OFF_W-1:0] dx, dy, dz;
    logic [gcfs_pkg::MAG_W-1:0] dx_mag, dy_mag, dz_mag;

    always_comb
    begin
        int coef_xi;
        int coef_yi;
        logic signed [gcfs_pkg::COEF_W-1:0] coef_x;
        logic signed [gcfs_pkg::COEF_W-1:0] coef_y;
        logic signed [gcfs_pkg::OFF_W-1:0]  xs_s;
        logic signed [gcfs_pkg::OFF_W-1:0]  ys_s;
        coef_xi = 2 * int'(j_reg) - int'(cols_eff) + 1;
        coef_yi = 2 * int'(i_reg) - int'(rows_eff) + 1;
        coef_x  = gcfs_pkg::COEF_W'(coef_xi);
        coef_y  = gcfs_pkg::COEF_W'(coef_yi);
        xs_s    = $signed({{(gcfs_pkg::OFF_W-31){1'b0}}, x_spacing_reg});
        ys_s    = $signed({{(gcfs_pkg::OFF_W-31){1'b0}}, y_spacing_reg});
        dx = (gcfs_pkg::OFF_W'(qx_reg) <<< 1) - gcfs_pkg::OFF_W'(coef_x) * xs_s;
        dy = (gcfs_pkg::OFF_W'(qy_reg) <<< 1) - gcfs_pkg::OFF_W'(coef_y) * ys_s;
        dz = gcfs_pkg::OFF_W'(qz_reg) <<< 1;
        dx_mag = gcfs_pkg::MAG_W'(dx[gcfs_pkg::OFF_W-1] ? -dx : dx);
        dy_mag = gcfs_pkg::MAG_W'(dy[gcfs_pkg::OFF_W-1] ? -dy : dy);
        dz_mag = gcfs_pkg::MAG_W'(dz[gcfs_pkg::OFF_W-1] ? -dz : dz);
    end

    // Shift that brings the largest offset below 2^16.
    logic [gcfs_pkg::MAG_W-1:0] max_mag;
    logic [gcfs_pkg::SH_W-1:0]  shift_amt;

    always_comb
    begin
        logic [gcfs_pkg::MAG_W-1:0] m_ab;
        m_ab    = (a_reg > b_reg) ? a_reg : b_reg;
        max_mag = (c_reg > m_ab) ? c_reg : m_ab;
        shift_amt = '0;
        for (int k = gcfs_pkg::MANT_W; k < gcfs_pkg::MAG_W; k++)
        begin
            if (max_mag[k])
            begin
                shift_amt = gcfs_pkg::SH_W'(k - gcfs_pkg::MANT_W + 1);
            end
        end
    end

    // Top set bit of D and D brought into [2^31, 2^32).
    logic [gcfs_pkg::P_W-1:0] d_top;
    logic [31:0]              d_norm;

    always_comb
    begin
        d_top = '0;
        for (int k = 0; k < gcfs_pkg::D_W; k++)
        begin
            if (d_reg[k])
            begin
                d_top = gcfs_pkg::P_W'(k);
            end
        end
        if (d_top >= gcfs_pkg::P_W'(31))
        begin
            d_norm = 32'(d_reg >> (d_top - gcfs_pkg::P_W'(31)));
        end
        else
        begin
            d_norm = 32'(d_reg << (gcfs_pkg::P_W'(31) - d_top));
        end
    end

    // Per-axis selections for the term stage.
    logic [gcfs_pkg::MANT_W-1:0] comp_sel;
    logic                        comp_neg;

    always_comb
    begin
        case (comp_reg)
            gcfs_pkg::AXIS_X: begin comp_sel = u_reg; comp_neg = sx_reg; end
            gcfs_pkg::AXIS_Y: begin comp_sel = v_reg; comp_neg = sy_reg; end
            default:          begin comp_sel = w_reg; comp_neg = sz_reg; end
        endcase
    end

    // Magnitude of the saturated field component used by the norm.
    logic [63:0] f_abs;

    always_comb
    begin
        logic signed [63:0] f_sel;
        case (cnt_reg[3:2])
            gcfs_pkg::AXIS_X: f_sel = fx_reg;
            gcfs_pkg::AXIS_Y: f_sel = fy_reg;
            default:          f_sel = fz_reg;
        endcase
        f_abs = f_sel[63] ? 64'(-f_sel) : 64'(f_sel);
    end

    // Shared multiplier. Its product is registered and used in the next cycle.
    logic [gcfs_pkg::MUL_A_W-1:0] mul_a;
    logic [gcfs_pkg::MUL_B_W-1:0] mul_b;
    logic [31:0]                  charge_mag;
    logic [gcfs_pkg::R_W-1:0]     sqrt_trial;

    assign charge_mag = charge_reg[31] ? 32'(-charge_reg) : 32'(charge_reg);
    assign sqrt_trial = r_reg | (gcfs_pkg::R_W'(1) << cnt_reg[4:0]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_KMUL:
            begin
                mul_a = gcfs_pkg::MUL_A_W'(charge_mag);
                mul_b = gcfs_pkg::MUL_B_W'(gcfs_pkg::K_MICRO);
            end
            ST_SQ:
            begin
                case (cnt_reg[1:0])
                    gcfs_pkg::AXIS_X: mul_a = gcfs_pkg::MUL_A_W'(u_reg);
                    gcfs_pkg::AXIS_Y: mul_a = gcfs_pkg::MUL_A_W'(v_reg);
                    default:          mul_a = gcfs_pkg::MUL_A_W'(w_reg);
                endcase
                mul_b = gcfs_pkg::MUL_B_W'(mul_a);
            end
            ST_SQRT:
            begin
                mul_a = gcfs_pkg::MUL_A_W'(sqrt_trial);
                mul_b = gcfs_pkg::MUL_B_W'(sqrt_trial);
            end
            ST_DMUL:
            begin
                mul_a = sum_reg;
                mul_b = gcfs_pkg::MUL_B_W'(r_reg);
            end
            ST_TERM:
            begin
                case (cnt_reg[2:0])
                    3'd0:
                    begin
                        mul_a = gcfs_pkg::MUL_A_W'(comp_sel);
                        mul_b = rec_reg;
                    end
                    3'd1:
                    begin
                        mul_a = k_reg[33:0];
                        mul_b = t1_reg[32:0];
                    end
                    3'd2:
                    begin
                        mul_a = k_reg[33:0];
                        mul_b = gcfs_pkg::MUL_B_W'(t1_reg[48:33]);
                    end
                    3'd3:
                    begin
                        mul_a = gcfs_pkg::MUL_A_W'(k_reg[44:34]);
                        mul_b = t1_reg[32:0];
                    end
                    default:
                    begin
                        mul_a = gcfs_pkg::MUL_A_W'(k_reg[44:34]);
                        mul_b = gcfs_pkg::MUL_B_W'(t1_reg[48:33]);
                    end
                endcase
            end
            ST_MSQ:
            begin
                mul_a = gcfs_pkg::MUL_A_W'(cnt_reg[1] ? f_abs[63:32] : f_abs[31:0]);
                mul_b = gcfs_pkg::MUL_B_W'(cnt_reg[0] ? f_abs[63:32] : f_abs[31:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Term shift, signed term and the norm's root step.
    logic signed [gcfs_pkg::ACC_W-1:0] term_val;
    logic [gcfs_pkg::TP_W-1:0]         part_add;
    logic [127:0]                      sq_add;
    logic [67:0]                       root_cur;
    logic [67:0]                       root_try;

    always_comb
    begin
        int e_i;
        logic [gcfs_pkg::ACC_W-1:0] t_mag;
        e_i = 2 - int'(p_reg) - 2 * int'(s_reg);
        if (e_i >= 0)
        begin
            t_mag = gcfs_pkg::ACC_W'(tp_reg) << 2'(e_i);
        end
        else
        begin
            t_mag = gcfs_pkg::ACC_W'(tp_reg) >> 7'(-e_i);
        end
        term_val = (comp_neg != charge_reg[31]) ? -$signed(t_mag) : $signed(t_mag);

        case (cnt_reg[2:0])
            3'd2:    part_add = gcfs_pkg::TP_W'(prod_reg) << 33;
            3'd3:    part_add = gcfs_pkg::TP_W'(prod_reg) << 34;
            3'd4:    part_add = gcfs_pkg::TP_W'(prod_reg) << 67;
            default: part_add = gcfs_pkg::TP_W'(prod_reg);
        endcase

        case (cnt_reg[1:0])
            2'd0:    sq_add = 128'(prod_reg[63:0]);
            2'd3:    sq_add = 128'(prod_reg[63:0]) << 64;
            default: sq_add = 128'(prod_reg[63:0]) << 32;
        endcase

        root_cur = {mrem_reg, sq_reg[127:126]};
        root_try = 68'({root_reg, 2'b01});
    end

    function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
        if (v[127:63] == '0 || v[127:63] == '1)
        begin
            return v[63:0];
        end
        return v[127] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    endfunction

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_KMUL;
            ST_KMUL:   if (phase_reg) state_next = ST_OFFSET;
            ST_OFFSET: state_next = (dx == '0 && dy == '0 && dz == '0) ? ST_FIN : ST_SHIFT;
            ST_SHIFT:  state_next = ST_SQ;
            ST_SQ:     if (phase_reg && cnt_reg == 7'd2) state_next = ST_SQRT;
            ST_SQRT:   if (phase_reg && cnt_reg == 7'd0) state_next = ST_DMUL;
            ST_DMUL:   if (phase_reg) state_next = ST_NORM;
            ST_NORM:   state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 7'd0) state_next = ST_TERM;
            ST_TERM:   if (phase_reg && cnt_reg == 7'd4) state_next = ST_TACC;
            ST_TACC:   state_next = (comp_reg == gcfs_pkg::AXIS_Z) ? ST_NEXT : ST_TERM;
            ST_NEXT:
            begin
                if (gcfs_pkg::COLE_W'(j_reg) == cols_eff - 1'b1 &&
                    gcfs_pkg::ROWE_W'(i_reg) == rows_eff - 1'b1)
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    state_next = ST_OFFSET;
                end
            end
            ST_SAT:    state_next = ST_MSQ;
            ST_MSQ:    if (phase_reg && cnt_reg == 7'd11) state_next = ST_MSQRT;
            ST_MSQRT:  if (cnt_reg == 7'd0) state_next = ST_FIN;
            ST_FIN:    if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            comp_reg      <= gcfs_pkg::AXIS_X;
            i_reg         <= '0;
            j_reg         <= '0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            grid_rows_reg <= 7'd1;
            grid_cols_reg <= 7'd1;
            x_spacing_reg <= 31'd65536;
            y_spacing_reg <= 31'd65536;
            charge_reg    <= 32'sd65536;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    gcfs_pkg::CFG_GRID_ROWS:    grid_rows_reg <= cfg_data[6:0];
                    gcfs_pkg::CFG_GRID_COLS:    grid_cols_reg <= cfg_data[6:0];
                    gcfs_pkg::CFG_X_SPACING:    x_spacing_reg <= cfg_data[30:0];
                    gcfs_pkg::CFG_Y_SPACING:    y_spacing_reg <= cfg_data[30:0];
                    gcfs_pkg::CFG_CHARGE_VALUE: charge_reg    <= $signed(cfg_data);
                    default: ;
                endcase
            end

            if (state_reg == ST_FIN && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    phase_reg <= 1'b0;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    sing_reg  <= 1'b0;
                end
                ST_OFFSET:
                begin
                    if (dx == '0 && dy == '0 && dz == '0)
                    begin
                        sing_reg <= 1'b1;
                    end
                end
                ST_SHIFT:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= 1'b0;
                end
                ST_SQ:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        cnt_reg <= (cnt_reg == 7'd2) ? 7'd16 : cnt_reg + 7'd1;
                    end
                end
                ST_SQRT:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg && cnt_reg != 7'd0)
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                ST_NORM:
                begin
                    cnt_reg <= 7'd32;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        comp_reg  <= gcfs_pkg::AXIS_X;
                        phase_reg <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                ST_TERM:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg && cnt_reg != 7'd4)
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ST_TACC:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= 1'b0;
                    comp_reg  <= comp_reg + 2'd1;
                end
                ST_NEXT:
                begin
                    if (gcfs_pkg::COLE_W'(j_reg) == cols_eff - 1'b1)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_SAT:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= 1'b0;
                end
                ST_MSQ:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        cnt_reg <= (cnt_reg == 7'd11) ? 7'd63 : cnt_reg + 7'd1;
                    end
                end
                ST_MSQRT:
                begin
                    if (cnt_reg != 7'd0)
                    begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                ST_KMUL:
                begin
                    phase_reg <= !phase_reg;
                end
                ST_DMUL:
                begin
                    phase_reg <= !phase_reg;
                end
                ST_FIN: ;
                default: ;
            endcase
        end
    end

    // Datapath registers; they need no reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        case (state_reg)
            ST_IDLE:
            begin
                qx_reg <= in_data.query_x;
                qy_reg <= in_data.query_y;
                qz_reg <= in_data.query_z;
                ax_reg <= '0;
                ay_reg <= '0;
                az_reg <= '0;
            end
            ST_KMUL:
            begin
                if (phase_reg)
                begin
                    k_reg <= prod_reg[gcfs_pkg::K_W-1:0];
                end
            end
            ST_OFFSET:
            begin
                a_reg  <= dx_mag;
                b_reg  <= dy_mag;
                c_reg  <= dz_mag;
                sx_reg <= dx[gcfs_pkg::OFF_W-1];
                sy_reg <= dy[gcfs_pkg::OFF_W-1];
                sz_reg <= dz[gcfs_pkg::OFF_W-1];
            end
            ST_SHIFT:
            begin
                s_reg   <= shift_amt;
                u_reg   <= gcfs_pkg::MANT_W'(a_reg >> shift_amt);
                v_reg   <= gcfs_pkg::MANT_W'(b_reg >> shift_amt);
                w_reg   <= gcfs_pkg::MANT_W'(c_reg >> shift_amt);
                sum_reg <= '0;
                r_reg   <= '0;
            end
            ST_SQ:
            begin
                if (phase_reg)
                begin
                    sum_reg <= sum_reg + gcfs_pkg::S_W'(prod_reg);
                end
            end
            ST_SQRT:
            begin
                if (phase_reg && prod_reg <= gcfs_pkg::MUL_P_W'(sum_reg))
                begin
                    r_reg <= sqrt_trial;
                end
            end
            ST_DMUL:
            begin
                if (phase_reg)
                begin
                    d_reg <= prod_reg[gcfs_pkg::D_W-1:0];
                end
            end
            ST_NORM:
            begin
                p_reg   <= d_top;
                dn_reg  <= d_norm;
                rem_reg <= 64'h8000000000000000;
                rec_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem_reg >= (64'(dn_reg) << cnt_reg[5:0]))
                begin
                    rem_reg <= rem_reg - (64'(dn_reg) << cnt_reg[5:0]);
                    rec_reg <= rec_reg | (gcfs_pkg::REC_W'(1) << cnt_reg[5:0]);
                end
            end
            ST_TERM:
            begin
                if (phase_reg)
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        t1_reg <= prod_reg[gcfs_pkg::T1_W-1:0];
                        tp_reg <= '0;
                    end
                    else
                    begin
                        tp_reg <= tp_reg + part_add;
                    end
                end
            end
            ST_TACC:
            begin
                case (comp_reg)
                    gcfs_pkg::AXIS_X: ax_reg <= ax_reg + term_val;
                    gcfs_pkg::AXIS_Y: ay_reg <= ay_reg + term_val;
                    default:          az_reg <= az_reg + term_val;
                endcase
            end
            ST_SAT:
            begin
                fx_reg   <= sat64(ax_reg);
                fy_reg   <= sat64(ay_reg);
                fz_reg   <= sat64(az_reg);
                sq_reg   <= '0;
                mrem_reg <= '0;
                root_reg <= '0;
            end
            ST_MSQ:
            begin
                if (phase_reg)
                begin
                    sq_reg <= sq_reg + sq_add;
                end
            end
            ST_MSQRT:
            begin
                sq_reg <= sq_reg << 2;
                if (root_cur >= root_try)
                begin
                    mrem_reg <= 66'(root_cur - root_try);
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    mrem_reg <= 66'(root_cur);
                    root_reg <= {root_reg[62:0], 1'b0};
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (sing_reg)
                    begin
                        out_reg.field_x         <= '0;
                        out_reg.field_y         <= '0;
                        out_reg.field_z         <= '0;
                        out_reg.field_magnitude <= '0;
                    end
                    else
                    begin
                        out_reg.field_x         <= fx_reg;
                        out_reg.field_y         <= fy_reg;
                        out_reg.field_z         <= fz_reg;
                        out_reg.field_magnitude <= root_reg[63] ? '1 : root_reg[62:0];
                    end
                    out_reg.singular <= sing_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A new result appears only after the finish step.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish step");

    // A singular result carries zero fields.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.singular) |->
            (out_data.field_x == '0 && out_data.field_y == '0 &&
             out_data.field_z == '0 && out_data.field_magnitude == '0))
        else $error("singular result with nonzero fields");

    // An accepted item starts the charge scaling step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == ST_KMUL)
        else $error("accepted item did not start the sequencer");

    // The divider never runs past its top quotient bit.
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= 7'd32)
        else $error("divider step out of range");

endmodule
